// File: rtl/ipv6_header_ext_parser_top_assert.svh
// Assertion macros shared by the checker of the IPv6 header parser.
`ifndef IPV6_HEADER_EXT_PARSER_TOP_ASSERT_SVH
`define IPV6_HEADER_EXT_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ihp_pkg.sv
// Types, constants and helper functions of the IPv6 header parser.
package ihp_pkg;

    localparam int unsigned FixedLen    = 40;
    localparam int unsigned FragSpan    = 8;
    localparam int unsigned MaxExt      = 11;
    localparam int unsigned MinExtBytes = 2;
    localparam int unsigned IpVersion   = 6;

    localparam logic [7:0] PROTO_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] PROTO_ROUTING    = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT   = 8'd44;
    localparam logic [7:0] PROTO_DST_OPTS   = 8'd60;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_VERSION = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        t_status     status;
        logic [7:0]  tclass;
        logic [19:0] flow_id;
        logic [7:0]  hops_left;
        logic [7:0]  final_protocol;
        logic [3:0]  ext_count;
        logic [15:0] payload_offset;
        logic [15:0] payload_bytes;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dst_high;
        logic [63:0] dst_low;
    } t_result;

    function automatic logic is_ext(input logic [7:0] proto);
        return (proto == PROTO_HOP_BY_HOP) || (proto == PROTO_ROUTING) ||
               (proto == PROTO_FRAGMENT) || (proto == PROTO_DST_OPTS);
    endfunction

endpackage

// File: rtl/ihp_in_reg.sv
// Input register of the IPv6 header parser: holds one accepted byte beat.
module ihp_in_reg
    import ihp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_beat i_beat,
    input  logic  i_take,
    output logic  o_stall,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_in_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

// File: rtl/ihp_walk.sv
// Header capture and extension-header walk, one byte per cycle unless stalled.
module ihp_walk
    import ihp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_beat   i_beat,
    input  logic    i_out_free,
    output logic    o_take,
    output logic    o_res_load,
    output t_result o_res
);

    logic [15:0] r_index, n_index;
    logic [31:0] r_w0, n_w0;
    logic [15:0] r_plen, n_plen;
    logic [7:0]  r_hop, n_hop;
    logic [63:0] r_addr [4];
    logic [63:0] n_addr [4];
    logic [7:0]  r_cur, n_cur;
    logic [15:0] r_hs, n_hs;
    logic [7:0]  r_pend_nh, n_pend_nh;
    logic [11:0] r_pend_span, n_pend_span;
    logic        r_pend_known, n_pend_known;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_done, n_done;

    logic [15:0] s_pos;
    logic [7:0]  s_byte;
    logic [5:0]  s_addr_k;
    logic [15:0] s_off;
    logic [15:0] s_rem;
    logic [3:0]  s_cnt;

    assign s_pos    = r_index;
    assign s_byte   = i_beat.data_byte;
    assign s_addr_k = 6'(s_pos[5:0] - 6'd8);
    assign s_off    = 16'(s_pos - r_hs);

    assign o_take     = i_valid && (!i_beat.last_byte || i_out_free);
    assign o_res_load = o_take && i_beat.last_byte;

    always_comb begin
        n_index      = r_index;
        n_w0         = r_w0;
        n_plen       = r_plen;
        n_hop        = r_hop;
        n_addr       = r_addr;
        n_cur        = r_cur;
        n_hs         = r_hs;
        n_pend_nh    = r_pend_nh;
        n_pend_span  = r_pend_span;
        n_pend_known = r_pend_known;
        n_cnt        = r_cnt;
        n_done       = r_done;
        o_res        = '0;
        s_rem        = '0;
        s_cnt        = '0;

        if (o_take && (r_index != 16'hFFFF)) begin
            n_index = 16'(r_index + 16'd1);
            if (s_pos < 16'd4) begin
                case (s_pos[1:0])
                    2'd0:    n_w0[31:24] = s_byte;
                    2'd1:    n_w0[23:16] = s_byte;
                    2'd2:    n_w0[15:8]  = s_byte;
                    default: n_w0[7:0]   = s_byte;
                endcase
            end else if (s_pos == 16'd4) begin
                n_plen[15:8] = s_byte;
            end else if (s_pos == 16'd5) begin
                n_plen[7:0] = s_byte;
            end else if (s_pos == 16'd6) begin
                n_cur = s_byte;
            end else if (s_pos == 16'd7) begin
                n_hop = s_byte;
            end else if (s_pos < 16'(FixedLen)) begin
                n_addr[s_addr_k[4:3]][{3'(3'd7 - s_addr_k[2:0]), 3'b000} +: 8] = s_byte;
            end else if (!r_done && is_ext(r_cur) && (s_pos >= r_hs)) begin
                if (s_off == 16'd0) begin
                    n_pend_nh = s_byte;
                    if (r_cur == PROTO_FRAGMENT) begin
                        n_pend_known = 1'b1;
                        n_pend_span  = 12'(FragSpan);
                    end else begin
                        n_pend_known = 1'b0;
                        n_pend_span  = '0;
                    end
                end else if ((s_off == 16'd1) && (r_cur != PROTO_FRAGMENT)) begin
                    n_pend_known = 1'b1;
                    n_pend_span  = 12'({1'b0, s_byte, 3'b000}) + 12'd8;
                end else if (r_pend_known &&
                             (s_off == {4'b0000, 12'(r_pend_span - 12'd1)})) begin
                    n_cur        = r_pend_nh;
                    n_hs         = 16'(s_pos + 16'd1);
                    n_pend_nh    = '0;
                    n_pend_span  = '0;
                    n_pend_known = 1'b0;
                    n_cnt        = 4'(r_cnt + 4'd1);
                    if (4'(r_cnt + 4'd1) >= 4'(MaxExt)) begin
                        n_done = 1'b1;
                    end
                end
            end
        end

        if (n_index < 16'(FixedLen)) begin
            o_res.status = STATUS_SHORT;
        end else if (n_w0[31:28] != 4'(IpVersion)) begin
            o_res.status = STATUS_VERSION;
        end else begin
            s_rem = (n_index >= n_hs) ? 16'(n_index - n_hs) : 16'd0;
            s_cnt = n_cnt;
            if (!n_done && is_ext(n_cur) && (s_rem >= 16'(MinExtBytes))) begin
                s_cnt = 4'(n_cnt + 4'd1);
            end
            o_res.status         = STATUS_OK;
            o_res.tclass         = n_w0[27:20];
            o_res.flow_id        = n_w0[19:0];
            o_res.hops_left      = n_hop;
            o_res.final_protocol = n_cur;
            o_res.ext_count      = s_cnt;
            o_res.payload_offset = n_hs;
            o_res.payload_bytes  = (s_rem < n_plen) ? s_rem : n_plen;
            o_res.src_high       = n_addr[0];
            o_res.src_low        = n_addr[1];
            o_res.dst_high       = n_addr[2];
            o_res.dst_low        = n_addr[3];
        end

        if (o_res_load) begin
            n_index      = '0;
            n_cur        = '0;
            n_hs         = 16'(FixedLen);
            n_pend_nh    = '0;
            n_pend_span  = '0;
            n_pend_known = 1'b0;
            n_cnt        = '0;
            n_done       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index      <= '0;
            r_cur        <= '0;
            r_hs         <= 16'(FixedLen);
            r_pend_known <= 1'b0;
            r_cnt        <= '0;
            r_done       <= 1'b0;
        end else begin
            r_index      <= n_index;
            r_cur        <= n_cur;
            r_hs         <= n_hs;
            r_pend_known <= n_pend_known;
            r_cnt        <= n_cnt;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w0        <= n_w0;
        r_plen      <= n_plen;
        r_hop       <= n_hop;
        r_addr      <= n_addr;
        r_pend_nh   <= n_pend_nh;
        r_pend_span <= n_pend_span;
    end

endmodule

// File: rtl/ihp_out_reg.sv
// Result register of the IPv6 header parser with its output handshake.
module ihp_out_reg
    import ihp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_out_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/ipv6_header_ext_parser_top.sv
// Top level of the IPv6 header parser with extension-header skip.
// The input channel carries one packet byte per beat, in network order, with
// i_last_byte marking the final byte of each packet.
// The output channel carries one result beat per packet: status, fixed header
// fields, both addresses, the final next header, the extension count and the
// payload offset and length.
// A byte is taken into an input register, and while it is held there the
// capture and walk logic updates the parser state and, on the last byte,
// loads the result register, which then holds a valid result beat until
// the receiver takes it.
// One byte is accepted in every cycle while the input does not stall, packets
// follow one another without gaps, and a byte without the last mark never waits for the output side.
// When the receiver stalls, the result holds; a last byte then waits in the
// input register until the result register is free, and the input stalls.
// Reset empties both registers and returns the parser to the start of a packet.
module ipv6_header_ext_parser_top
    import ihp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_tclass,
    output logic [19:0] o_flow_id,
    output logic [7:0]  o_hops_left,
    output logic [7:0]  o_final_protocol,
    output logic [3:0]  o_ext_count,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_payload_bytes,
    output logic [63:0] o_src_high,
    output logic [63:0] o_src_low,
    output logic [63:0] o_dst_high,
    output logic [63:0] o_dst_low
);

    t_beat   s_in_beat;
    t_beat   s_reg_beat;
    logic    s_reg_valid;
    logic    s_take;
    logic    s_out_free;
    logic    s_res_load;
    t_result s_res;
    t_result s_out_res;

    assign s_in_beat.data_byte = i_data_byte;
    assign s_in_beat.last_byte = i_last_byte;

    ihp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_beat     (s_in_beat),
        .i_take     (s_take),
        .o_stall    (o_in_stall),
        .o_valid    (s_reg_valid),
        .o_beat     (s_reg_beat)
    );

    ihp_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_reg_valid),
        .i_beat     (s_reg_beat),
        .i_out_free (s_out_free),
        .o_take     (s_take),
        .o_res_load (s_res_load),
        .o_res      (s_res)
    );

    ihp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_res_load),
        .i_res       (s_res),
        .i_out_stall (i_out_stall),
        .o_free      (s_out_free),
        .o_valid     (o_out_valid),
        .o_res       (s_out_res)
    );

    assign o_status         = s_out_res.status;
    assign o_tclass         = s_out_res.tclass;
    assign o_flow_id        = s_out_res.flow_id;
    assign o_hops_left      = s_out_res.hops_left;
    assign o_final_protocol = s_out_res.final_protocol;
    assign o_ext_count      = s_out_res.ext_count;
    assign o_payload_offset = s_out_res.payload_offset;
    assign o_payload_bytes  = s_out_res.payload_bytes;
    assign o_src_high       = s_out_res.src_high;
    assign o_src_low        = s_out_res.src_low;
    assign o_dst_high       = s_out_res.dst_high;
    assign o_dst_low        = s_out_res.dst_low;

endmodule

// File: rtl/ihp_checker.sv
// Port-level checker of the IPv6 header parser and its bind statement.
`include "ipv6_header_ext_parser_top_assert.svh"

module ihp_checker
    import ihp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [7:0]  o_tclass,
    input logic [19:0] o_flow_id,
    input logic [7:0]  o_hops_left,
    input logic [7:0]  o_final_protocol,
    input logic [3:0]  o_ext_count,
    input logic [15:0] o_payload_offset,
    input logic [15:0] o_payload_bytes,
    input logic [63:0] o_src_high,
    input logic [63:0] o_src_low,
    input logic [63:0] o_dst_high,
    input logic [63:0] o_dst_low
);

    logic s_ok;
    logic s_fields_zero;

    assign s_ok = o_out_valid && (o_status == STATUS_OK);
    assign s_fields_zero = (o_tclass == '0) && (o_flow_id == '0) &&
                           (o_hops_left == '0) && (o_final_protocol == '0) &&
                           (o_ext_count == '0) && (o_payload_offset == '0) &&
                           (o_payload_bytes == '0) && (o_src_high == '0) &&
                           (o_src_low == '0) && (o_dst_high == '0) && (o_dst_low == '0);

    `IHP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_status) && $stable(o_payload_offset),
        "Stalled result beat changed.")
    `IHP_ASSERT_IMPL(a_error_zero, i_clk, i_rst_n,
        o_out_valid && ((o_status == STATUS_SHORT) || (o_status == STATUS_VERSION)),
        s_fields_zero, "Error result carries non-zero fields.")
    `IHP_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_out_valid,
        (o_status == STATUS_OK) || (o_status == STATUS_SHORT) || (o_status == STATUS_VERSION),
        "Result status code is undefined.")
    `IHP_ASSERT_IMPL(a_walk_bounds, i_clk, i_rst_n, s_ok,
        (o_ext_count <= 4'(MaxExt)) && (o_payload_offset >= 16'(FixedLen)),
        "Extension count or payload offset out of range.")
    `IHP_ASSERT_IMPL(a_payload_fits, i_clk, i_rst_n, s_ok,
        (17'(o_payload_offset) + 17'(o_payload_bytes)) <= 17'h0FFFF,
        "Payload extends beyond the packet.")

endmodule

bind ipv6_header_ext_parser_top ihp_checker u_ihp_checker (.*);

// File: test/tb_ipv6_header_ext_parser_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the IPv6 header parser with extension-header skip.
module tb_ipv6_header_ext_parser_top;
    import ihp_pkg::*;

    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_RANDOM = 2;

    typedef struct {
        logic [7:0] octet;
        logic       fin;
        bit         hold;
        bit         calm;
    } t_wire_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_tclass;
    logic [19:0] o_flow_id;
    logic [7:0]  o_hops_left;
    logic [7:0]  o_final_protocol;
    logic [3:0]  o_ext_count;
    logic [15:0] o_payload_offset;
    logic [15:0] o_payload_bytes;
    logic [63:0] o_src_high;
    logic [63:0] o_src_low;
    logic [63:0] o_dst_high;
    logic [63:0] o_dst_low;

    t_wire_byte  tx_bytes[$];
    logic [7:0]  pkt[$];
    t_result     expected_headers[$];
    logic [7:0]  ext_codes [4] = '{PROTO_HOP_BY_HOP, PROTO_ROUTING, PROTO_FRAGMENT,
                                   PROTO_DST_OPTS};
    logic [7:0]  upper_codes [4] = '{8'd6, 8'd17, 8'd58, 8'd59};
    bit          calm = 1'b0;
    int          results_due = 0;
    int          results_seen = 0;
    int          mismatches = 0;

    int          rx_count;
    logic [31:0] lead_word;
    logic [15:0] declared_len;
    logic [7:0]  hop_field;
    logic [63:0] addr_words [4];
    logic [7:0]  walk_proto;
    logic [15:0] seg_start;
    logic [7:0]  pend_next;
    logic [15:0] pend_span;
    bit          pend_known;
    logic [3:0]  ext_passed;
    bit          walk_stop;

    ipv6_header_ext_parser_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_tclass         (o_tclass),
        .o_flow_id        (o_flow_id),
        .o_hops_left      (o_hops_left),
        .o_final_protocol (o_final_protocol),
        .o_ext_count      (o_ext_count),
        .o_payload_offset (o_payload_offset),
        .o_payload_bytes  (o_payload_bytes),
        .o_src_high       (o_src_high),
        .o_src_low        (o_src_low),
        .o_dst_high       (o_dst_high),
        .o_dst_low        (o_dst_low)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit chains_on(input logic [7:0] proto);
        case (proto)
            PROTO_HOP_BY_HOP, PROTO_ROUTING, PROTO_FRAGMENT, PROTO_DST_OPTS: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_parser();
        rx_count     = 0;
        lead_word    = '0;
        declared_len = '0;
        hop_field    = '0;
        for (int k = 0; k < 4; k++) addr_words[k] = '0;
        walk_proto   = '0;
        seg_start    = 16'(FixedLen);
        pend_next    = '0;
        pend_span    = '0;
        pend_known   = 1'b0;
        ext_passed   = '0;
        walk_stop    = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        int         pos;
        int         off;
        int         rem;
        logic [3:0] cnt;
        t_result    res;
        pos = rx_count;
        if (rx_count < 65535) begin
            rx_count++;
            if (pos < 4) begin
                lead_word[8 * (3 - pos) +: 8] = b;
            end else if (pos < 6) begin
                declared_len[8 * (5 - pos) +: 8] = b;
            end else if (pos == 6) begin
                walk_proto = b;
            end else if (pos == 7) begin
                hop_field = b;
            end else if (pos < FixedLen) begin
                addr_words[(pos - 8) / 8][8 * (7 - (pos - 8) % 8) +: 8] = b;
            end else if (!walk_stop && chains_on(walk_proto) && pos >= seg_start) begin
                off = pos - seg_start;
                if (off == 0) begin
                    pend_next  = b;
                    pend_known = (walk_proto == PROTO_FRAGMENT);
                    pend_span  = pend_known ? 16'(FragSpan) : 16'd0;
                end else if (off == 1 && walk_proto != PROTO_FRAGMENT) begin
                    pend_known = 1'b1;
                    pend_span  = (16'(b) + 16'd1) * 16'd8;
                end
                if (pend_known && pend_span != 0 && off == int'(pend_span) - 1) begin
                    walk_proto = pend_next;
                    seg_start  = 16'(pos + 1);
                    pend_next  = '0;
                    pend_span  = '0;
                    pend_known = 1'b0;
                    ext_passed = ext_passed + 4'd1;
                    if (ext_passed >= MaxExt) walk_stop = 1'b1;
                end
            end
        end
        if (fin) begin
            res = '0;
            if (rx_count < FixedLen) begin
                res.status = STATUS_SHORT;
            end else if (lead_word[31:28] != IpVersion) begin
                res.status = STATUS_VERSION;
            end else begin
                rem = (rx_count >= seg_start) ? rx_count - int'(seg_start) : 0;
                cnt = ext_passed;
                if (!walk_stop && chains_on(walk_proto) && rem >= MinExtBytes) cnt++;
                res.status         = STATUS_OK;
                res.tclass         = lead_word[27:20];
                res.flow_id        = lead_word[19:0];
                res.hops_left      = hop_field;
                res.final_protocol = walk_proto;
                res.ext_count      = cnt;
                res.payload_offset = seg_start;
                res.payload_bytes  = (rem < declared_len) ? 16'(rem) : declared_len;
                res.src_high       = addr_words[0];
                res.src_low        = addr_words[1];
                res.dst_high       = addr_words[2];
                res.dst_low        = addr_words[3];
            end
            expected_headers.push_back(res);
            results_due++;
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s is %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic put_fixed(input logic [3:0] ver, input logic [7:0] tc,
                             input logic [19:0] flow, input logic [15:0] plen,
                             input logic [7:0] nxt, input logic [7:0] hop, input int fill);
        logic [31:0] lead;
        lead = {ver, tc, flow};
        pkt.delete();
        for (int k = 0; k < 4; k++) pkt.push_back(lead[8 * (3 - k) +: 8]);
        pkt.push_back(plen[15:8]);
        pkt.push_back(plen[7:0]);
        pkt.push_back(nxt);
        pkt.push_back(hop);
        for (int k = 0; k < 32; k++)
            pkt.push_back(fill == FILL_RANDOM ? 8'($urandom) : {8{fill == FILL_ONES}});
    endtask

    task automatic put_ext(input logic [7:0] kind, input logic [7:0] nxt, input logic [7:0] len);
        pkt.push_back(nxt);
        if (kind == PROTO_FRAGMENT) begin
            repeat (FragSpan - 1) pkt.push_back(8'($urandom));
        end else begin
            pkt.push_back(len);
            repeat ((int'(len) + 1) * 8 - 2) pkt.push_back(8'($urandom));
        end
    endtask

    task automatic set_exact_len();
        logic [15:0] plen;
        plen = 16'(pkt.size() - FixedLen);
        pkt[4] = plen[15:8];
        pkt[5] = plen[7:0];
    endtask

    task automatic send_packet(input int cut, input bit hold, input bit calm_flag);
        int         n;
        t_wire_byte w;
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int k = 0; k < n; k++) begin
            w.octet = pkt[k];
            w.fin   = (k == n - 1);
            w.hold  = hold && (k == 0);
            w.calm  = calm_flag;
            tx_bytes.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) parse_byte(i_data_byte, i_last_byte);
            if (!i_in_valid || !o_in_stall) begin
                if (tx_bytes.size() != 0 &&
                    !(tx_bytes[0].hold && results_seen != results_due) &&
                    (tx_bytes[0].calm || $urandom_range(99) >= 12)) begin
                    i_in_valid  <= 1'b1;
                    i_data_byte <= tx_bytes[0].octet;
                    i_last_byte <= tx_bytes[0].fin;
                    calm        <= tx_bytes[0].calm;
                    void'(tx_bytes.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_headers.size() == 0) begin
                    report_mismatch("unexpected result, status", o_status, '0);
                end else begin
                    want = expected_headers.pop_front();
                    check_field("status", o_status, want.status);
                    check_field("tclass", o_tclass, want.tclass);
                    check_field("flow_id", o_flow_id, want.flow_id);
                    check_field("hops_left", o_hops_left, want.hops_left);
                    check_field("final_protocol", o_final_protocol, want.final_protocol);
                    check_field("ext_count", o_ext_count, want.ext_count);
                    check_field("payload_offset", o_payload_offset, want.payload_offset);
                    check_field("payload_bytes", o_payload_bytes, want.payload_bytes);
                    check_field("src_high", o_src_high, want.src_high);
                    check_field("src_low", o_src_low, want.src_low);
                    check_field("dst_high", o_dst_high, want.dst_high);
                    check_field("dst_low", o_dst_low, want.dst_low);
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < 12);
        end
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int          n_bytes;
        int          n_pkts;
        int          n_ext;
        int          cut;
        int          mode;
        bit          hold;
        bit          calm_flag;
        logic [3:0]  ver;
        logic [7:0]  cur;
        logic [7:0]  nxt;
        logic [7:0]  final_next;
        logic [7:0]  len;
        logic [15:0] plen;
        clear_parser();

        // Packets shorter than the fixed header.
        pkt.delete();
        pkt.push_back(8'hFF);
        send_packet(0, 1'b0, 1'b0);
        put_fixed(4'd6, 8'h5A, 20'h12345, 16'd0, 8'd59, 8'd64, FILL_RANDOM);
        send_packet(39, 1'b0, 1'b0);

        // Bare fixed headers at the field extremes.
        put_fixed(4'd6, 8'hFF, 20'hFFFFF, 16'hFFFF, 8'hFF, 8'hFF, FILL_ONES);
        send_packet(0, 1'b0, 1'b0);
        put_fixed(4'd6, 8'h00, 20'h00000, 16'h0000, PROTO_HOP_BY_HOP, 8'h00, FILL_ZERO);
        send_packet(0, 1'b0, 1'b0);

        // Wrong version.
        put_fixed(4'd4, 8'($urandom), 20'($urandom), 16'd20, 8'd6, 8'($urandom), FILL_RANDOM);
        repeat (20) pkt.push_back(8'($urandom));
        send_packet(0, 1'b0, 1'b0);
        put_fixed(4'hF, 8'($urandom), 20'($urandom), 16'd0, 8'd17, 8'($urandom), FILL_RANDOM);
        send_packet(0, 1'b0, 1'b0);

        // Truncated extension headers: one byte, two bytes, a partial fragment.
        put_fixed(4'd6, 8'($urandom), 20'($urandom), 16'd8, PROTO_HOP_BY_HOP, 8'd1, FILL_RANDOM);
        pkt.push_back(8'd17);
        send_packet(0, 1'b0, 1'b0);
        put_fixed(4'd6, 8'($urandom), 20'($urandom), 16'd32, PROTO_ROUTING, 8'd2, FILL_RANDOM);
        put_ext(PROTO_ROUTING, 8'd17, 8'd3);
        send_packet(42, 1'b0, 1'b0);
        put_fixed(4'd6, 8'($urandom), 20'($urandom), 16'd8, PROTO_FRAGMENT, 8'd3, FILL_RANDOM);
        put_ext(PROTO_FRAGMENT, 8'd17, 8'd0);
        send_packet(45, 1'b0, 1'b0);
        send_packet(41, 1'b0, 1'b0);

        // A full chain of every extension type, then a short declared length.
        put_fixed(4'd6, 8'($urandom), 20'($urandom), 16'd0, PROTO_HOP_BY_HOP, 8'd4, FILL_RANDOM);
        put_ext(PROTO_HOP_BY_HOP, PROTO_ROUTING, 8'd0);
        put_ext(PROTO_ROUTING, PROTO_FRAGMENT, 8'd1);
        put_ext(PROTO_FRAGMENT, PROTO_DST_OPTS, 8'd0);
        put_ext(PROTO_DST_OPTS, 8'd6, 8'd2);
        repeat (20) pkt.push_back(8'($urandom));
        set_exact_len();
        send_packet(0, 1'b1, 1'b0);
        pkt[4] = 8'd0;
        pkt[5] = 8'd5;
        send_packet(0, 1'b0, 1'b0);

        // Eleven headers end the walk; the first run also carries a twelfth.
        for (int v = 0; v < 2; v++) begin
            put_fixed(4'd6, 8'($urandom), 20'($urandom), 16'hFFFF, ext_codes[0], 8'd5,
                      FILL_RANDOM);
            cur = ext_codes[0];
            for (int k = 0; k < 12 - v; k++) begin
                if (k == 10) nxt = (v == 0) ? PROTO_ROUTING : 8'd17;
                else nxt = ext_codes[(k + 1) % 4];
                put_ext(cur, nxt, 8'(k % 3));
                cur = nxt;
            end
            repeat (10) pkt.push_back(8'($urandom));
            send_packet(0, 1'b0, 1'b0);
        end

        // Largest length byte, and an extension type with exactly two bytes left.
        put_fixed(4'd6, 8'($urandom), 20'($urandom), 16'd0, PROTO_DST_OPTS, 8'd6, FILL_RANDOM);
        put_ext(PROTO_DST_OPTS, 8'd17, 8'd255);
        repeat (4) pkt.push_back(8'($urandom));
        set_exact_len();
        send_packet(0, 1'b0, 1'b0);
        put_fixed(4'd6, 8'($urandom), 20'($urandom), 16'd100, PROTO_HOP_BY_HOP, 8'd7,
                  FILL_RANDOM);
        put_ext(PROTO_HOP_BY_HOP, PROTO_FRAGMENT, 8'd0);
        repeat (2) pkt.push_back(8'($urandom));
        send_packet(0, 1'b0, 1'b0);

        n_bytes = 0;
        n_pkts  = 0;
        while (n_bytes < 1950 || n_pkts < 24) begin
            calm_flag = (n_pkts >= 12 && n_pkts < 20);
            hold      = (n_pkts % 15 == 7);
            cut       = 0;
            if ($urandom_range(99) < 6) begin
                pkt.delete();
                repeat ($urandom_range(1, 90)) pkt.push_back(8'($urandom));
            end else begin
                n_ext = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
                ver = 4'd6;
                if ($urandom_range(99) < 8) begin
                    ver = 4'($urandom_range(14));
                    if (ver >= 4'd6) ver++;
                end
                final_next = ($urandom_range(4) == 0) ? 8'($urandom)
                                                      : upper_codes[$urandom_range(3)];
                cur = (n_ext > 0) ? ext_codes[$urandom_range(3)] : final_next;
                put_fixed(ver, 8'($urandom), 20'($urandom), 16'd0, cur, 8'($urandom),
                          FILL_RANDOM);
                for (int k = 0; k < n_ext; k++) begin
                    nxt = (k == n_ext - 1) ? final_next : ext_codes[$urandom_range(3)];
                    len = ($urandom_range(49) == 0) ? 8'($urandom_range(40))
                                                    : 8'($urandom_range(2));
                    put_ext(cur, nxt, len);
                    cur = nxt;
                end
                repeat ($urandom_range(24)) pkt.push_back(8'($urandom));
                mode = $urandom_range(3);
                if (mode < 2) plen = 16'(pkt.size() - FixedLen);
                else if (mode == 2) plen = 16'($urandom);
                else plen = 16'($urandom_range(64));
                pkt[4] = plen[15:8];
                pkt[5] = plen[7:0];
                if ($urandom_range(99) < 15) cut = $urandom_range(1, pkt.size());
            end
            n_bytes += (cut != 0) ? cut : pkt.size();
            n_pkts++;
            send_packet(cut, hold, calm_flag);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (tx_bytes.size() != 0 || i_in_valid || results_seen != results_due)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_headers.size() != 0)
            report_mismatch("results still outstanding", expected_headers.size(), '0);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ihp_pkg.sv
rtl/ihp_in_reg.sv
rtl/ihp_walk.sv
rtl/ihp_out_reg.sv
rtl/ipv6_header_ext_parser_top.sv
rtl/ihp_checker.sv
test/tb_ipv6_header_ext_parser_top.sv
